// ----- src/cac_pkg.sv -----
// Shared constants, codes and types for the context entry allocator.
`timescale 1ns / 1ps
`default_nettype none
package cac_pkg;

	// Table geometry
	localparam int ENTRIES = 8;
	localparam int LAST    = ENTRIES - 1;
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	// Item field widths
	localparam int ACTION_W = 2;
	localparam int CTX_W    = 2;
	localparam int IDX_W    = 3;
	localparam int STATUS_W = 2;
	localparam int FREE_W   = 4;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RESERVE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FREE    = 2'd2;

	// Context codes
	localparam logic [CTX_W-1:0] CTX_NORMAL    = 2'd0;
	localparam logic [CTX_W-1:0] CTX_RESERVED  = 2'd1;
	localparam logic [CTX_W-1:0] CTX_EXCLUSIVE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISUSE = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic load;    // capture the accepted item
		logic commit;  // update table state and load the result register
	} cac_cmd_t;

endpackage
`default_nettype wire

// ----- src/cac_if.sv -----
// Valid/ready channel interfaces for request and result items.
`timescale 1ns / 1ps
`default_nettype none
interface cac_in_if import cac_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CTX_W-1:0]    context_req;
	logic [IDX_W-1:0]    entry_index;

	modport source (output valid, action, context_req, entry_index, input ready);
	modport sink (input valid, action, context_req, entry_index, output ready);
endinterface

interface cac_out_if import cac_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [IDX_W-1:0]    granted_index;
	logic [FREE_W-1:0]   normal_free;
	logic [FREE_W-1:0]   reserved_free;
	logic                exclusive_free;
	logic                table_empty;

	modport source (output valid, status, granted_index, normal_free, reserved_free,
		exclusive_free, table_empty, input ready);
	modport sink (input valid, status, granted_index, normal_free, reserved_free,
		exclusive_free, table_empty, output ready);
endinterface
`default_nettype wire

// ----- src/cac_ctrl.sv -----
// Controller: sequences one item at a time and owns the result valid flag.
`timescale 1ns / 1ps
`default_nettype none
module cac_ctrl import cac_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  wire logic out_ready,
	output cac_cmd_t  cmd
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	// Handshake decode
	always_comb begin
		in_ready   = (state_q == S_IDLE);
		cmd.load   = in_valid && in_ready;
		cmd.commit = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	end

	assign out_valid = out_valid_q;

	// State and result slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ----- src/cac_datapath.sv -----
// Datapath: in-use flags, free counters, lowest-empty search and result register.
`timescale 1ns / 1ps
`default_nettype none
module cac_datapath import cac_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire cac_cmd_t            cmd,
	input  wire logic [ACTION_W-1:0] action,
	input  wire logic [CTX_W-1:0]    context_req,
	input  wire logic [IDX_W-1:0]    entry_index,
	output logic [STATUS_W-1:0]      status,
	output logic [IDX_W-1:0]         granted_index,
	output logic [FREE_W-1:0]        normal_free,
	output logic [FREE_W-1:0]        reserved_free,
	output logic                     exclusive_free,
	output logic                     table_empty
);

	// Captured item
	logic [ACTION_W-1:0] action_q;
	logic [CTX_W-1:0]    ctx_q;
	logic [IDX_W-1:0]    idx_q;

	// Table state
	logic [ENTRIES-1:0] flags_q;
	logic [CNT_W-1:0]   normal_q;
	logic [CNT_W-1:0]   reserved_q;
	logic               excl_q;

	// Result register
	logic [STATUS_W-1:0] status_q;
	logic [IDX_W-1:0]    grant_q;
	logic                empty_q;

	// Next-state values
	logic [ENTRIES-1:0]  flags_d;
	logic [CNT_W-1:0]    normal_d;
	logic [CNT_W-1:0]    reserved_d;
	logic                excl_d;
	logic [STATUS_W-1:0] status_d;
	logic [IDX_W-1:0]    grant_d;
	logic                found;
	logic [IDX_W-1:0]    lowest;
	logic [CNT_W-1:0]    ctx_cnt;
	logic                ctx_bad;
	logic                idx_bad;
	logic                is_last;
	logic [CNT_W+1:0]    total;

	// Lowest empty entry below the exclusive one
	always_comb begin
		found  = 1'b0;
		lowest = '0;
		for (int i = LAST - 1; i >= 0; i--) begin
			if (!flags_q[i]) begin
				found  = 1'b1;
				lowest = IDX_W'(i);
			end
		end
	end

	// Operation decode and state update
	always_comb begin
		flags_d    = flags_q;
		normal_d   = normal_q;
		reserved_d = reserved_q;
		excl_d     = excl_q;
		status_d   = ST_OK;
		grant_d    = '0;
		ctx_bad    = (ctx_q != CTX_NORMAL) && (ctx_q != CTX_RESERVED)
			&& (ctx_q != CTX_EXCLUSIVE);
		idx_bad    = !(int'(idx_q) < ENTRIES);
		is_last    = (int'(idx_q) == LAST);
		case (ctx_q)
			CTX_NORMAL:   ctx_cnt = normal_q;
			CTX_RESERVED: ctx_cnt = reserved_q;
			default:      ctx_cnt = CNT_W'(excl_q);
		endcase
		case (action_q)
			ACT_ALLOC: begin
				if (ctx_bad) begin
					status_d = ST_MISUSE;
				end else if (ctx_cnt == '0) begin
					status_d = ST_NONE;
				end else if (ctx_q == CTX_EXCLUSIVE) begin
					if (flags_q[LAST]) begin
						status_d = ST_NONE;
					end else begin
						flags_d[LAST] = 1'b1;
						excl_d        = 1'b0;
						grant_d       = IDX_W'(LAST);
					end
				end else if (!found) begin
					status_d = ST_NONE;
				end else begin
					flags_d[lowest] = 1'b1;
					grant_d         = lowest;
					if (ctx_q == CTX_NORMAL) normal_d = normal_q - 1'b1;
					else reserved_d = reserved_q - 1'b1;
				end
			end
			ACT_RESERVE: begin
				if (normal_q == '0) begin
					status_d = ST_MISUSE;
				end else begin
					normal_d   = normal_q - 1'b1;
					reserved_d = reserved_q + 1'b1;
				end
			end
			ACT_FREE: begin
				if (ctx_bad || idx_bad) begin
					status_d = ST_MISUSE;
				end else if (!flags_q[idx_q]) begin
					status_d = ST_MISUSE;
				end else if (is_last != (ctx_q == CTX_EXCLUSIVE)) begin
					status_d = ST_MISUSE;
				end else begin
					flags_d[idx_q] = 1'b0;
					case (ctx_q)
						CTX_NORMAL:   normal_d = normal_q + 1'b1;
						CTX_RESERVED: reserved_d = reserved_q + 1'b1;
						default:      excl_d = 1'b1;
					endcase
				end
			end
			default: status_d = ST_MISUSE;
		endcase
		total = (CNT_W+2)'(normal_d) + (CNT_W+2)'(reserved_d) + (CNT_W+2)'(excl_d);
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= action;
			ctx_q    <= context_req;
			idx_q    <= entry_index;
		end
	end

	// Table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q    <= '0;
			normal_q   <= CNT_W'(ENTRIES - 1);
			reserved_q <= '0;
			excl_q     <= 1'b1;
		end else if (cmd.commit) begin
			flags_q    <= flags_d;
			normal_q   <= normal_d;
			reserved_q <= reserved_d;
			excl_q     <= excl_d;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
			grant_q  <= grant_d;
			empty_q  <= (int'(total) == ENTRIES);
		end
	end

	assign status         = status_q;
	assign granted_index  = grant_q;
	assign normal_free    = FREE_W'(normal_q);
	assign reserved_free  = FREE_W'(reserved_q);
	assign exclusive_free = excl_q;
	assign table_empty    = empty_q;

endmodule
`default_nettype wire

// ----- src/context_entry_allocator_unit.sv -----
// Top level of the context entry allocator: controller plus datapath.
// Usage:
//   in_ch carries request items (action, context_req, entry_index); out_ch
//   carries one result item per request (status, granted_index, the three
//   free counters and table_empty). Both use valid/ready; an item moves when
//   both are high at a rising edge.
//   Sequence: the accepting edge captures the item; a later edge searches
//   the flags, updates the state and loads the result register, once the
//   output register is empty or its result is being taken.
//   A new item is taken only after the one in flight is committed; the
//   single flag search and counter update unit handles one item at a time.
//   in_ch.ready is high whenever no item is in flight, even while a previous
//   result waits in the output register.
//   If out_ch.ready stays low, the finished result holds, the next item waits
//   in the capture register and in_ch.ready stays low until the result is
//   taken.
//   Reset (arst_n low): all entries empty, normal counter ENTRIES-1, reserved
//   counter 0, exclusive counter 1, no result pending. No clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module context_entry_allocator_unit import cac_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	cac_in_if.sink    in_ch,
	cac_out_if.source out_ch
);

	cac_cmd_t cmd;

	// Sequencing
	cac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// Table and result
	cac_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.action         (in_ch.action),
		.context_req    (in_ch.context_req),
		.entry_index    (in_ch.entry_index),
		.status         (out_ch.status),
		.granted_index  (out_ch.granted_index),
		.normal_free    (out_ch.normal_free),
		.reserved_free  (out_ch.reserved_free),
		.exclusive_free (out_ch.exclusive_free),
		.table_empty    (out_ch.table_empty)
	);

`ifndef SYNTHESIS
	// One item in flight: no new accept right after one
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("request accepted while an item is in flight");

	// A fresh result always follows an earlier accept
	a_result_follows_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_ch.valid) |-> $past(in_ch.valid && in_ch.ready, 2))
		else $error("result appeared without a matching request");

	// A failed result carries no grant
	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.status != ST_OK |-> out_ch.granted_index == '0)
		else $error("grant index set on a rejected item");

	// Normal plus reserved never exceed the shared entries
	a_counter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> ((FREE_W+1)'(out_ch.normal_free)
			+ (FREE_W+1)'(out_ch.reserved_free)) <= (FREE_W+1)'(LAST))
		else $error("free counters exceed table capacity");
`endif

endmodule
`default_nettype wire
